// ----- rtl/core/pvsa_pkg.sv -----
// Shared types, codes and sizes for the priority voice slot allocator.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package pvsa_pkg;

    // Table size and derived widths
    localparam int SLOTS   = 64;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Request kinds
    localparam logic [2:0] KIND_ALLOC       = 3'd0;
    localparam logic [2:0] KIND_ALLOC_FORCE = 3'd1;
    localparam logic [2:0] KIND_DROP        = 3'd2;
    localparam logic [2:0] KIND_DETACH      = 3'd3;
    localparam logic [2:0] KIND_START       = 3'd4;
    localparam logic [2:0] KIND_SET_PRI     = 3'd5;
    localparam logic [2:0] KIND_KILL        = 3'd6;
    localparam logic [2:0] KIND_UPDATE      = 3'd7;

    // Play status codes
    localparam logic [1:0] ST_PLAYING  = 2'd0;
    localparam logic [1:0] ST_IDLE     = 2'd1;
    localparam logic [1:0] ST_STOPPING = 2'd2;

    // DSP action codes
    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_START      = 3'd1;
    localparam logic [2:0] ACT_STOP       = 3'd2;
    localparam logic [2:0] ACT_FORCE_STOP = 3'd3;
    localparam logic [2:0] ACT_FINISH     = 3'd4;

    // Kill threshold after reset
    localparam logic [7:0] KILL_THR_RESET = 8'h7F;

    // One slot of the table
    typedef struct packed {
        logic        free;
        logic [7:0]  pri;
        logic [31:0] age;
        logic [1:0]  status;
        logic        start;
        logic        stop;
        logic        att;
    } t_slot_entry;

    localparam t_slot_entry SLOT_RESET = '{
        free:   1'b1,
        pri:    8'd0,
        age:    32'd0,
        status: ST_IDLE,
        start:  1'b0,
        stop:   1'b0,
        att:    1'b0
    };

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the accepted request
        logic scan_rd;  // issue the next scan read
        logic apply;    // write back and present the result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;  // last slot address is being issued
        logic out_full;   // result register still holds an untaken result
    } t_dp_sts;

    // Kinds that search the whole table
    function automatic logic is_scan_kind(input logic [2:0] kind);
        return (kind == KIND_ALLOC) || (kind == KIND_ALLOC_FORCE) || (kind == KIND_KILL);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pvsa_ctrl.sv -----
// Sequencing state machine for the slot allocator: accept, fetch or scan and drain, apply.
// Depends on pvsa_pkg for command and status types.
`default_nettype none

module pvsa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [2:0]       i_kind,
    input  wire pvsa_pkg::t_dp_sts i_sts,
    output pvsa_pkg::t_dp_cmd     o_cmd
);
    import pvsa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_APPLY = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = is_scan_kind(i_kind) ? S_SCAN : S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_APPLY;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (!i_sts.out_full) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pvsa_datapath.sv -----
// Slot table memory, scan comparator, per-kind update logic and result register.
// Depends on pvsa_pkg for the slot entry type, codes and command/status types.
`default_nettype none

module pvsa_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pvsa_pkg::t_dp_cmd  i_cmd,
    output pvsa_pkg::t_dp_sts       o_sts,
    input  wire logic [2:0]         i_kind,
    input  wire logic [5:0]         i_slot,
    input  wire logic [7:0]         i_priority_req,
    input  wire logic               i_has_client,
    input  wire logic               i_finished,
    input  wire logic               i_client_continue,
    input  wire logic               i_client_keeps,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [7:0]         i_cfg_wr_data,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [15:0]             m_axis_tdata
);
    import pvsa_pkg::*;

    // Slot table: one memory plus a valid bit per entry
    t_slot_entry mem [SLOTS];
    logic [SLOTS-1:0] r_valid;

    // Captured request
    logic [2:0] r_kind;
    logic [5:0] r_slot;
    logic [7:0] r_req;
    logic       r_has_client;
    logic       r_fin;
    logic       r_cont;
    logic       r_keeps;
    logic [7:0] r_kill_thr;

    // Read port
    logic [SLOT_AW-1:0] rd_addr;
    t_slot_entry        r_rd_data;
    logic               r_rd_vld;
    logic [SLOT_AW-1:0] r_rd_idx;
    t_slot_entry        rd_entry;

    // Scan state
    logic [SLOT_AW-1:0] r_scan_idx;
    logic               r_cmp_en;
    logic               r_best_found;
    logic [SLOT_AW-1:0] r_best_idx;
    t_slot_entry        r_best_entry;
    logic               r_free_found;
    logic [SLOT_AW-1:0] r_free_idx;
    t_slot_entry        r_free_entry;
    logic               cand;
    logic               better;
    logic               take_free;

    // Apply stage
    logic [SLOT_AW-1:0] slot_addr;
    logic               in_range;
    logic               scan_kind;
    logic               use_free;
    logic               found;
    logic [SLOT_AW-1:0] sel_idx;
    t_slot_entry        sel_entry;
    t_slot_entry        n_entry;
    logic               wr_en;
    logic               n_ok;
    logic [5:0]         n_slot_out;
    logic               n_notice;
    logic [2:0]         n_action;
    logic               n_flush;

    // Result register
    logic               r_out_vld;
    logic               r_ok;
    logic [5:0]         r_slot_out;
    logic               r_notice;
    logic [2:0]         r_action;
    logic               r_flush;

    // Release a slot: detach, free, cancel start, request stop if playing
    function automatic t_slot_entry drop_entry(input t_slot_entry e);
        t_slot_entry d;
        d       = e;
        d.att   = 1'b0;
        d.free  = 1'b1;
        d.start = 1'b0;
        if (e.status == ST_PLAYING) begin
            d.stop   = 1'b1;
            d.status = ST_STOPPING;
        end
        return d;
    endfunction

    assign slot_addr = SLOT_AW'(r_slot);
    assign in_range  = (32'(r_slot) < 32'(SLOTS));
    assign scan_kind = is_scan_kind(r_kind);
    assign rd_addr   = i_cmd.scan_rd ? r_scan_idx : slot_addr;
    assign rd_entry  = r_rd_vld ? r_rd_data : SLOT_RESET;

    // Status to controller
    assign o_sts.scan_last = (r_scan_idx == SLOT_AW'(SLOTS - 1));
    assign o_sts.out_full  = r_out_vld && !m_axis_tready;

    // Request capture and threshold register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind       <= i_kind;
            r_slot       <= i_slot;
            r_req        <= i_priority_req;
            r_has_client <= i_has_client;
            r_fin        <= i_finished;
            r_cont       <= i_client_continue;
            r_keeps      <= i_client_keeps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kill_thr <= KILL_THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_kill_thr <= i_cfg_wr_data;
        end
    end

    // Memory read, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
        r_rd_idx  <= rd_addr;
    end

    // Memory write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[sel_idx] <= n_entry;
        end
    end

    // Valid bits: an unwritten entry reads as the reset entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[rd_addr];
            if (wr_en) begin
                r_valid[sel_idx] <= 1'b1;
            end
        end
    end

    // Scan candidate test on the entry just read
    always_comb begin
        if (r_kind == KIND_KILL) begin
            cand = !rd_entry.free && (rd_entry.status == ST_PLAYING) &&
                   (rd_entry.pri <= r_kill_thr);
        end else begin
            cand = !rd_entry.free && (rd_entry.pri <= r_req);
        end
        better = !r_best_found || (rd_entry.pri < r_best_entry.pri) ||
                 ((rd_entry.pri == r_best_entry.pri) && (rd_entry.age > r_best_entry.age));
        take_free = rd_entry.free && !r_free_found && (r_kind != KIND_KILL);
    end

    // Scan address counter and best-so-far registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en     <= 1'b0;
            r_best_found <= 1'b0;
            r_free_found <= 1'b0;
            r_scan_idx   <= '0;
        end else begin
            r_cmp_en <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_best_found <= 1'b0;
                r_free_found <= 1'b0;
                r_scan_idx   <= '0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                if (r_cmp_en && take_free) begin
                    r_free_found <= 1'b1;
                end
                if (r_cmp_en && cand && better) begin
                    r_best_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_en && take_free) begin
            r_free_idx   <= r_rd_idx;
            r_free_entry <= rd_entry;
        end
        if (r_cmp_en && cand && better) begin
            r_best_idx   <= r_rd_idx;
            r_best_entry <= rd_entry;
        end
    end

    // Per-kind update of the selected slot
    always_comb begin
        use_free   = 1'b0;
        found      = 1'b0;
        sel_idx    = slot_addr;
        sel_entry  = rd_entry;
        n_entry    = rd_entry;
        n_ok       = 1'b1;
        n_slot_out = r_slot;
        n_notice   = 1'b0;
        n_action   = ACT_NONE;
        n_flush    = 1'b0;
        wr_en      = 1'b0;

        if (scan_kind) begin
            use_free  = r_free_found;
            found     = use_free || r_best_found;
            sel_idx   = use_free ? r_free_idx : r_best_idx;
            sel_entry = use_free ? r_free_entry : r_best_entry;
            n_entry   = sel_entry;
            if (!found) begin
                n_ok       = 1'b0;
                n_slot_out = '0;
            end else begin
                if (r_kind == KIND_ALLOC_FORCE) begin
                    n_entry.status = ST_IDLE;
                end
                n_notice = n_entry.att;
                n_entry  = drop_entry(n_entry);
                if (r_kind != KIND_KILL) begin
                    n_entry.free = 1'b0;
                    n_entry.pri  = r_req;
                    n_entry.age  = '0;
                    n_entry.att  = r_has_client;
                end
                n_slot_out = 6'(sel_idx);
                wr_en      = i_cmd.apply;
            end
        end else if (in_range) begin
            wr_en = i_cmd.apply;
            case (r_kind)
                KIND_DROP: begin
                    n_notice = sel_entry.att;
                    n_entry  = drop_entry(sel_entry);
                end
                KIND_DETACH: begin
                    n_entry.att = 1'b0;
                end
                KIND_START: begin
                    n_entry.start = 1'b1;
                end
                KIND_SET_PRI: begin
                    n_entry.pri  = r_req;
                    n_entry.free = 1'b0;
                end
                KIND_UPDATE: begin
                    if (r_fin) begin
                        // playback finished
                        n_entry.stop = 1'b0;
                        if (sel_entry.status == ST_PLAYING && !(sel_entry.att && r_keeps)) begin
                            n_entry.free = 1'b1;
                        end
                        n_entry.status = ST_IDLE;
                        n_action       = ACT_FINISH;
                        n_flush        = 1'b1;
                    end else if (sel_entry.stop) begin
                        n_entry.stop = 1'b0;
                        n_action     = ACT_FORCE_STOP;
                        n_flush      = 1'b1;
                    end else if (sel_entry.status == ST_STOPPING) begin
                        // stop still in flight
                        wr_en = 1'b0;
                    end else if (sel_entry.start && sel_entry.status == ST_IDLE) begin
                        n_entry.start  = 1'b0;
                        n_entry.status = ST_PLAYING;
                        n_action       = ACT_START;
                        n_flush        = 1'b1;
                    end else if (sel_entry.status == ST_IDLE) begin
                        wr_en = 1'b0;
                    end else if (sel_entry.att && !r_cont) begin
                        // owner asked to stop
                        n_entry.status = ST_IDLE;
                        if (!r_keeps) begin
                            n_entry.free = 1'b1;
                        end
                        n_action = ACT_STOP;
                        n_flush  = 1'b1;
                    end else begin
                        n_entry.age = sel_entry.age + 32'd1;
                        n_flush     = sel_entry.att;
                    end
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.apply) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_ok       <= n_ok;
            r_slot_out <= n_slot_out;
            r_notice   <= n_notice;
            r_action   <= n_action;
            r_flush    <= n_flush;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'd0, r_flush, r_action, r_notice, r_slot_out, r_ok};

endmodule

`default_nettype wire

// ----- rtl/core/priority_voice_slot_allocator_top.sv -----
// Top level of the priority voice slot allocator: controller plus datapath.
// Depends on pvsa_pkg, pvsa_ctrl and pvsa_datapath.
//
// Channel   Direction  Handshake              Contents
// s_axis    in         tvalid/tready          tuser kind, tdata request fields
// m_axis    out        tvalid/tready          tdata result fields
// cfg       in         i_cfg_wr_en            kill threshold (8 bit)
//
// A table request (alloc, forced alloc, kill lowest) reads every slot once through
// the single table read port, then writes back the chosen slot and registers the
// result; the next request can be taken in the cycle after that write-back.
// Any other request reads its own slot, then writes it back and registers the result.
// A new request is taken while the previous result waits; the write-back stalls
// only while the result register is still full. Reset is synchronous, active low,
// and needs no clearing pass: per-slot valid bits stand in for the table reset.
`default_nettype none

module priority_voice_slot_allocator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // slot[5:0], priority_req[13:6], has_client[14],
                                             // finished[15], client_continue[16],
                                             // client_keeps[17], zero[23:18]
    input  wire logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // ok[0], slot_out[6:1], dropped_notice[7],
                                             // dsp_action[10:8], flush[11], zero[15:12]
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data   // kill_threshold
);
    import pvsa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    pvsa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_kind        (s_axis_tuser),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    // Table, scan and result path
    pvsa_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_kind            (s_axis_tuser),
        .i_slot            (s_axis_tdata[5:0]),
        .i_priority_req    (s_axis_tdata[13:6]),
        .i_has_client      (s_axis_tdata[14]),
        .i_finished        (s_axis_tdata[15]),
        .i_client_continue (s_axis_tdata[16]),
        .i_client_keeps    (s_axis_tdata[17]),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- test/priority_voice_slot_allocator_top_test.sv -----
// Self-checking testbench for priority_voice_slot_allocator_top: stream requests in,
// results checked against a behavioural model of the voice slot table kept here.
// Depends on pvsa_pkg and the RTL of the allocator; nothing else.
`default_nettype none

module priority_voice_slot_allocator_top_test;
    import pvsa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 120;   // result count at which the receiver holds off
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 2 * SLOTS + 8;

    // One request and one result, field by field
    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] slot;
        logic [7:0] pri;
        logic       has_client;
        logic       finished;
        logic       cont;
        logic       keeps;
    } t_voice_req;

    typedef struct packed {
        logic       ok;
        logic [5:0] slot;
        logic       notice;
        logic [2:0] action;
        logic       flush;
    } t_voice_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = '0;

    // Model of the slot table and the kill threshold
    logic        vc_free     [SLOTS];
    logic [7:0]  vc_pri      [SLOTS];
    logic [31:0] vc_age      [SLOTS];
    logic [1:0]  vc_status   [SLOTS];
    logic        vc_start_req[SLOTS];
    logic        vc_stop_req [SLOTS];
    logic        vc_owner    [SLOTS];
    logic [7:0]  kill_thr_mdl;

    t_voice_req    pending_reqs[$];
    t_voice_result expected_results[$];
    t_voice_req    cur_req;
    int            issued_total = 0;
    int            results_seen = 0;
    int            errors = 0;
    int            hold_left = 0;
    int            cycles = 0;
    bit            steady = 1'b0;

    priority_voice_slot_allocator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Victim search: first free slot for allocation, else lowest priority at or
    // under the limit, oldest among equals, lowest index on a full tie
    function automatic int pick_victim(logic [7:0] limit, bit kill_rule);
        bit         found;
        logic [7:0] best_pri;
        logic [31:0] best_age;
        int         best;
        found    = 1'b0;
        best_pri = 8'hFF;
        best_age = '0;
        best     = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (vc_free[i]) begin
                if (!kill_rule)
                    return i;
                continue;
            end
            if (kill_rule && vc_status[i] != ST_PLAYING)
                continue;
            if (vc_pri[i] > limit)
                continue;
            if (!found || vc_pri[i] < best_pri ||
                (vc_pri[i] == best_pri && vc_age[i] > best_age)) begin
                found    = 1'b1;
                best_pri = vc_pri[i];
                best_age = vc_age[i];
                best     = i;
            end
        end
        return best;
    endfunction

    // Release a slot; returns whether an attached owner hears about it
    function automatic logic release_slot(int s);
        logic told;
        told            = vc_owner[s];
        vc_owner[s]     = 1'b0;
        vc_free[s]      = 1'b1;
        vc_start_req[s] = 1'b0;
        if (vc_status[s] == ST_PLAYING) begin
            vc_stop_req[s] = 1'b1;
            vc_status[s]   = ST_STOPPING;
        end
        return told;
    endfunction

    // Advance the table by one request and work out the result it gives
    function automatic t_voice_result apply_voice_request(t_voice_req rq);
        t_voice_result r;
        int            c;
        int            s;
        logic          att;
        r = '{ok: 1'b1, slot: rq.slot, notice: 1'b0, action: ACT_NONE, flush: 1'b0};
        s = rq.slot;
        if (rq.kind == KIND_ALLOC || rq.kind == KIND_ALLOC_FORCE || rq.kind == KIND_KILL) begin
            c = (rq.kind == KIND_KILL) ? pick_victim(kill_thr_mdl, 1'b1)
                                       : pick_victim(rq.pri, 1'b0);
            if (c < 0) begin
                r.ok   = 1'b0;
                r.slot = '0;
            end else begin
                if (rq.kind == KIND_ALLOC_FORCE)
                    vc_status[c] = ST_IDLE;
                r.notice = release_slot(c);
                if (rq.kind != KIND_KILL) begin
                    vc_free[c]  = 1'b0;
                    vc_pri[c]   = rq.pri;
                    vc_age[c]   = '0;
                    vc_owner[c] = rq.has_client;
                end
                r.slot = 6'(c);
            end
        end else if (s < SLOTS) begin
            case (rq.kind)
                KIND_DROP: r.notice = release_slot(s);
                KIND_DETACH: vc_owner[s] = 1'b0;
                KIND_START: vc_start_req[s] = 1'b1;
                KIND_SET_PRI: begin
                    vc_pri[s]  = rq.pri;
                    vc_free[s] = 1'b0;
                end
                default: begin
                    att = vc_owner[s];
                    if (rq.finished) begin
                        vc_stop_req[s] = 1'b0;
                        if (vc_status[s] == ST_PLAYING && !(att && rq.keeps))
                            vc_free[s] = 1'b1;
                        vc_status[s] = ST_IDLE;
                        r.action = ACT_FINISH;
                        r.flush  = 1'b1;
                    end else if (vc_stop_req[s]) begin
                        vc_stop_req[s] = 1'b0;
                        r.action = ACT_FORCE_STOP;
                        r.flush  = 1'b1;
                    end else if (vc_status[s] == ST_STOPPING) begin
                        // still waiting for the stop to land
                    end else if (vc_start_req[s] && vc_status[s] == ST_IDLE) begin
                        vc_start_req[s] = 1'b0;
                        vc_status[s]    = ST_PLAYING;
                        r.action = ACT_START;
                        r.flush  = 1'b1;
                    end else if (vc_status[s] == ST_IDLE) begin
                        // nothing to do while idle
                    end else if (att && !rq.cont) begin
                        vc_status[s] = ST_IDLE;
                        if (!rq.keeps)
                            vc_free[s] = 1'b1;
                        r.action = ACT_STOP;
                        r.flush  = 1'b1;
                    end else begin
                        vc_age[s] = vc_age[s] + 32'd1;
                        r.flush   = att;
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Request driver: offers queued requests, predicts each one as it is taken
    always @(posedge i_clk) begin
        bit offer;
        offer = s_axis_tvalid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(apply_voice_request(cur_req));
                offer = 1'b0;
            end
            if (!offer && pending_reqs.size() != 0 &&
                (steady || $urandom_range(0, 99) >= 30)) begin
                cur_req = pending_reqs.pop_front();
                offer   = 1'b1;
                s_axis_tdata <= {6'd0, cur_req.keeps, cur_req.cont, cur_req.finished,
                                 cur_req.has_client, cur_req.pri, cur_req.slot};
                s_axis_tuser <= cur_req.kind;
            end
            s_axis_tvalid <= offer;
        end
    end

    // Result monitor: checks each result against the oldest prediction
    always @(posedge i_clk) begin
        t_voice_result want;
        bit            rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: tdata %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", want.ok, m_axis_tdata[0]);
                    check_field("slot_out", want.slot, m_axis_tdata[6:1]);
                    check_field("dropped_notice", want.notice, m_axis_tdata[7]);
                    check_field("dsp_action", want.action, m_axis_tdata[10:8]);
                    check_field("flush", want.flush, m_axis_tdata[11]);
                end
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                rdy = steady || ($urandom_range(0, 99) >= 30);
            end
            m_axis_tready <= rdy;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_req(logic [2:0] kind, int slot, logic [7:0] pri, logic client,
                            logic fin, logic cont, logic keeps);
        t_voice_req rq;
        rq = '{kind: kind, slot: 6'(slot), pri: pri, has_client: client,
               finished: fin, cont: cont, keeps: keeps};
        pending_reqs.push_back(rq);
        issued_total++;
    endtask

    function automatic logic [7:0] rand_priority();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_slot(int hot_max);
        return ($urandom_range(0, 4) != 0) ? $urandom_range(0, hot_max)
                                           : $urandom_range(0, SLOTS - 1);
    endfunction

    function automatic logic coin(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Any kind, any fields
    task automatic push_random_req(int hot_max);
        int         r;
        logic [2:0] k;
        r = $urandom_range(0, 99);
        if (r < 20)      k = KIND_ALLOC;
        else if (r < 28) k = KIND_ALLOC_FORCE;
        else if (r < 36) k = KIND_DROP;
        else if (r < 41) k = KIND_DETACH;
        else if (r < 56) k = KIND_START;
        else if (r < 61) k = KIND_SET_PRI;
        else if (r < 68) k = KIND_KILL;
        else             k = KIND_UPDATE;
        push_req(k, pick_slot(hot_max), rand_priority(), coin(50), coin(20), coin(75),
                 coin(50));
    endtask

    // A voice's life on one slot: start, a few playing updates, then some ending
    task automatic push_voice_life(int s);
        push_req(KIND_START, s, rand_priority(), coin(50), 1'b0, coin(50), coin(50));
        push_req(KIND_UPDATE, s, rand_priority(), coin(50), 1'b0, 1'b1, coin(50));
        repeat ($urandom_range(0, 3))
            push_req(KIND_UPDATE, s, rand_priority(), coin(50), 1'b0, 1'b1, coin(50));
        case ($urandom_range(0, 3))
            0: push_req(KIND_UPDATE, s, rand_priority(), coin(50), 1'b0, 1'b0, coin(50));
            1: push_req(KIND_DROP, s, rand_priority(), coin(50), 1'b0, coin(50), coin(50));
            2: push_req(KIND_UPDATE, s, rand_priority(), coin(50), 1'b1, coin(50), coin(50));
            default: push_req(KIND_KILL, s, rand_priority(), coin(50), coin(50), coin(50),
                              coin(50));
        endcase
    endtask

    // Sender pause: nothing more goes in until every result is back
    task automatic wait_drained();
        while (results_seen != issued_total)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int hot_max);
        int first;
        first = issued_total;
        while (issued_total - first < count) begin
            if (coin(50))
                push_voice_life(pick_slot(hot_max));
            else
                push_random_req(hot_max);
        end
        wait_drained();
    endtask

    task automatic write_kill_threshold(logic [7:0] thr);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= thr;
        kill_thr_mdl = thr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            vc_free[i]      = 1'b1;
            vc_pri[i]       = '0;
            vc_age[i]       = '0;
            vc_status[i]    = ST_IDLE;
            vc_start_req[i] = 1'b0;
            vc_stop_req[i]  = 1'b0;
            vc_owner[i]     = 1'b0;
        end
        kill_thr_mdl = KILL_THR_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one pass through each kind and the corner cases
        push_req(KIND_ALLOC, 0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
        push_req(KIND_ALLOC, 0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_req(KIND_START, 0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_req(KIND_UPDATE, 0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);    // start play
        push_req(KIND_UPDATE, 0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);    // owner keeps playing
        push_req(KIND_UPDATE, 0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);    // owner stops, keeps slot
        push_req(KIND_START, 1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_req(KIND_UPDATE, 1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        push_req(KIND_UPDATE, 1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);    // no owner: just ages
        push_req(KIND_KILL, 0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);      // kills playing slot 1
        push_req(KIND_UPDATE, 1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);    // forced stop
        push_req(KIND_UPDATE, 1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);    // waiting on stop
        push_req(KIND_UPDATE, 1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);    // finish reply
        push_req(KIND_KILL, 0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);      // nothing to kill
        push_req(KIND_SET_PRI, 63, 8'd200, 1'b0, 1'b0, 1'b0, 1'b0);
        push_req(KIND_DETACH, 0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_req(KIND_DROP, 0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_req(KIND_ALLOC_FORCE, 0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
        push_req(KIND_DROP, 63, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_req(KIND_UPDATE, 5, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);    // free slot finishing
        push_req(KIND_UPDATE, 0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);    // idle, no start
        push_req(KIND_START, 0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_req(KIND_UPDATE, 0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        push_req(KIND_DROP, 0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);      // owner told, stop asked
        push_req(KIND_UPDATE, 0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        wait_drained();

        // Kill may take anything; lifecycles on a few low slots
        write_kill_threshold(8'hFF);
        run_phase(250, 15);

        // Fill the table so that allocations must steal
        write_kill_threshold(8'h00);
        repeat (70)
            push_req(coin(80) ? KIND_ALLOC : KIND_ALLOC_FORCE, 0, rand_priority(),
                     coin(60), coin(50), coin(50), coin(50));
        run_phase(180, SLOTS - 1);

        // Back-to-back traffic with no idling on either side
        write_kill_threshold(8'($urandom_range(1, 254)));
        steady = 1'b1;
        run_phase(200, 7);
        steady = 1'b0;

        write_kill_threshold(KILL_THR_RESET);
        run_phase(150, 31);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
